/* sv/hvd_pkg.sv */
package hvd_pkg;

    localparam int MAX_STAGES         = 40;
    localparam int CORDIC_STAGES_DEF  = 24;
    localparam int MUL_LAT            = 3;
    localparam int DIV_LAT            = 7;
    localparam int SQRT_LAT           = 61;

    localparam logic [63:0] Q_ONE     = 64'd1 << 60;
    localparam logic [63:0] PI_NUM    = 64'd31415926;
    localparam logic [63:0] PI_DEN    = 64'd18000000000000000;
    localparam logic [63:0] TWO_R_CM  = 64'd1275627400;
    localparam logic [63:0] DIST_MAX  = 64'h7FFF_FFFF;

    localparam logic signed [30:0] LAT_LIMIT = 31'sd900000000;
    localparam logic signed [31:0] LON_LIMIT = 32'sd1800000000;
    localparam logic [31:0] HALF_TURN = 32'd1800000000;
    localparam logic [31:0] FULL_TURN = 32'd3600000000;

    // elaboration-time helpers for the constant tables
    function automatic logic [63:0] udiv(input logic [63:0] a, input logic [63:0] b);
        logic [64:0] r;
        logic [63:0] q;
        r = '0;
        q = '0;
        for (int j = 63; j >= 0; j--)
        begin
            r = {r[63:0], a[j]};
            if (r >= {1'b0, b})
            begin
                r = r - {1'b0, b};
                q[j] = 1'b1;
            end
        end
        return q;
    endfunction

    // floor(2^124 / d) for a divisor above 2^61
    function automatic logic [63:0] recip_q124(input logic [63:0] d);
        logic [64:0] r;
        logic [63:0] q;
        r = '0;
        q = '0;
        for (int j = 124; j >= 0; j--)
        begin
            r = {r[63:0], (j == 124)};
            if (r >= {1'b0, d})
            begin
                r = r - {1'b0, d};
                if (j < 64)
                    q[j] = 1'b1;
            end
        end
        return q;
    endfunction

    // atan(1/n) in Q62 by its power series
    function automatic logic [63:0] atan_recip(input logic [63:0] n);
        logic [63:0] p;
        logic [63:0] s;
        logic [63:0] t;
        p = udiv(64'd1 << 62, n);
        s = '0;
        for (int k = 0; k < 64; k++)
        begin
            if (p != 64'd0)
            begin
                t = udiv(p, 64'(2 * k + 1));
                if ((k % 2) == 0)
                    s = s + t;
                else
                    s = s - t;
                p = udiv(udiv(p, n), n);
            end
        end
        return s;
    endfunction

    function automatic logic [63:0] atan_entry(input int i);
        logic [63:0] v;
        if (i == 0)
            v = atan_recip(64'd2) + atan_recip(64'd3);
        else
            v = atan_recip(64'd1 << i);
        return (v + 64'd2) >> 2;
    endfunction

    function automatic logic [63:0] gain_sq(input int n);
        logic [63:0] p;
        p = Q_ONE;
        for (int i = 0; i < MAX_STAGES; i++)
        begin
            if (i < n)
                p = p + (p >> (2 * i));
        end
        return p;
    endfunction

    function automatic logic [63:0] deg_scale();
        logic [63:0] r;
        logic [63:0] q;
        r = PI_NUM;
        q = '0;
        for (int i = 0; i < 72; i++)
        begin
            r = r << 1;
            q = q << 1;
            if (r >= PI_DEN)
            begin
                r = r - PI_DEN;
                q = q | 64'd1;
            end
        end
        return q;
    endfunction

    function automatic int stage_count(input int s);
        return (s > MAX_STAGES) ? MAX_STAGES : s;
    endfunction

    localparam logic [63:0] DEG_SCALE = deg_scale();

endpackage

/* sv/haversine_distance.sv */
// throughput: one position pair per cycle while the output buffer is not full (pos_stall low);
//   every cordic iteration and root digit owns a pipeline stage, and a two-entry output
//   buffer parts the channels
// reset: rst_n clears the valid line and the output buffer count, no clearing pass
module haversine_distance #(
    parameter int CORDIC_STAGES = hvd_pkg::CORDIC_STAGES_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               pos_valid,
    output logic               pos_stall,
    input  logic signed [30:0] lat_a,
    input  logic signed [31:0] lon_a,
    input  logic signed [30:0] lat_b,
    input  logic signed [31:0] lon_b,
    output logic               dist_valid,
    input  logic               dist_stall,
    output logic [30:0]        distance_cm
);

    localparam int N     = hvd_pkg::stage_count(CORDIC_STAGES);
    localparam int ML    = hvd_pkg::MUL_LAT;
    localparam int H_STG = 2 + ML + N + ML + hvd_pkg::DIV_LAT + ML;
    localparam int LAT   = H_STG + 2 + hvd_pkg::SQRT_LAT + N + ML + 1;

    logic           en;
    logic [LAT-1:0] vld_reg;
    logic [1:0]     cnt_reg;
    logic [1:0]     cnt_next;
    logic [30:0]    buf0_reg;
    logic [30:0]    buf1_reg;
    logic [30:0]    buf0_next;
    logic [30:0]    buf1_next;
    logic           push;
    logic           pop;

    // stage a: saturate and difference
    logic signed [30:0] la_sat;
    logic signed [30:0] lb_sat;
    logic signed [31:0] oa_sat;
    logic signed [31:0] ob_sat;
    logic [31:0]        dlat_reg;
    logic [32:0]        dlon_reg;
    logic [30:0]        la_reg;
    logic [30:0]        lb_reg;

    // stage b: magnitudes and wrap
    logic [31:0] dlat_abs;
    logic [32:0] dlon_abs;
    logic [30:0] la_abs;
    logic [30:0] lb_abs;
    logic [30:0] dlat_b_reg;
    logic [31:0] dlon_b_reg;
    logic [29:0] mla_reg;
    logic [29:0] mlb_reg;

    logic [63:0]        z_dlat;
    logic [63:0]        z_dlon;
    logic [63:0]        z_la;
    logic [63:0]        z_lb;
    logic signed [63:0] ya;
    logic signed [63:0] yb;
    logic signed [63:0] x1;
    logic signed [63:0] x2;
    logic [63:0]        ya_mag;
    logic [63:0]        yb_mag;
    logic [63:0]        c1;
    logic [63:0]        c2;
    logic [63:0]        ya_sq;
    logic [63:0]        yb_sq;
    logic [63:0]        c_prod;
    logic [63:0]        sa;
    logic [63:0]        sb;
    logic [63:0]        cc;
    logic [63:0]        ccsb;
    logic [63:0]        sa_dly_reg [ML];
    logic [64:0]        h_sum;
    logic [60:0]        h_reg;
    logic [60:0]        h2_reg;
    logic [60:0]        omh_reg;
    logic [60:0]        root_h;
    logic [60:0]        root_omh;
    logic signed [63:0] th;
    logic [63:0]        th_pos;
    logic [63:0]        q;
    logic [63:0]        d_full;
    logic [30:0]        dist_reg;

    assign en        = (cnt_reg != 2'd2);
    assign pos_stall = ~en;

    always_comb
    begin
        la_sat = (lat_a > hvd_pkg::LAT_LIMIT) ? hvd_pkg::LAT_LIMIT :
                 (lat_a < -hvd_pkg::LAT_LIMIT) ? -hvd_pkg::LAT_LIMIT : lat_a;
        lb_sat = (lat_b > hvd_pkg::LAT_LIMIT) ? hvd_pkg::LAT_LIMIT :
                 (lat_b < -hvd_pkg::LAT_LIMIT) ? -hvd_pkg::LAT_LIMIT : lat_b;
        oa_sat = (lon_a > hvd_pkg::LON_LIMIT) ? hvd_pkg::LON_LIMIT :
                 (lon_a < -hvd_pkg::LON_LIMIT) ? -hvd_pkg::LON_LIMIT : lon_a;
        ob_sat = (lon_b > hvd_pkg::LON_LIMIT) ? hvd_pkg::LON_LIMIT :
                 (lon_b < -hvd_pkg::LON_LIMIT) ? -hvd_pkg::LON_LIMIT : lon_b;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dlat_reg <= {la_sat[30], la_sat} - {lb_sat[30], lb_sat};
            dlon_reg <= {oa_sat[31], oa_sat} - {ob_sat[31], ob_sat};
            la_reg   <= la_sat;
            lb_reg   <= lb_sat;
        end
    end

    always_comb
    begin
        dlat_abs = dlat_reg[31] ? (~dlat_reg + 32'd1) : dlat_reg;
        dlon_abs = dlon_reg[32] ? (~dlon_reg + 33'd1) : dlon_reg;
        la_abs   = la_reg[30] ? (~la_reg + 31'd1) : la_reg;
        lb_abs   = lb_reg[30] ? (~lb_reg + 31'd1) : lb_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dlat_b_reg <= dlat_abs[30:0];
            // beyond a half turn the short way round is the other side
            dlon_b_reg <= (dlon_abs[31:0] > hvd_pkg::HALF_TURN) ?
                          (hvd_pkg::FULL_TURN - dlon_abs[31:0]) : dlon_abs[31:0];
            mla_reg    <= la_abs[29:0];
            mlb_reg    <= lb_abs[29:0];
        end
    end

    // degrees to radians: half angles for the differences, full angles for latitudes
    hvd_mul #(.SHIFT(13)) u_rad_dlat (
        .clk (clk), .en (en), .a ({33'd0, dlat_b_reg}), .b (hvd_pkg::DEG_SCALE), .p (z_dlat)
    );
    hvd_mul #(.SHIFT(13)) u_rad_dlon (
        .clk (clk), .en (en), .a ({32'd0, dlon_b_reg}), .b (hvd_pkg::DEG_SCALE), .p (z_dlon)
    );
    hvd_mul #(.SHIFT(12)) u_rad_la (
        .clk (clk), .en (en), .a ({34'd0, mla_reg}), .b (hvd_pkg::DEG_SCALE), .p (z_la)
    );
    hvd_mul #(.SHIFT(12)) u_rad_lb (
        .clk (clk), .en (en), .a ({34'd0, mlb_reg}), .b (hvd_pkg::DEG_SCALE), .p (z_lb)
    );

    hvd_cordic #(.STAGES(N), .VECTOR(1'b0)) u_rot_dlat (
        .clk (clk), .en (en), .x_in (hvd_pkg::Q_ONE), .y_in ('0), .z_in (z_dlat),
        .x_out (), .y_out (ya), .z_out ()
    );
    hvd_cordic #(.STAGES(N), .VECTOR(1'b0)) u_rot_dlon (
        .clk (clk), .en (en), .x_in (hvd_pkg::Q_ONE), .y_in ('0), .z_in (z_dlon),
        .x_out (), .y_out (yb), .z_out ()
    );
    hvd_cordic #(.STAGES(N), .VECTOR(1'b0)) u_rot_la (
        .clk (clk), .en (en), .x_in (hvd_pkg::Q_ONE), .y_in ('0), .z_in (z_la),
        .x_out (x1), .y_out (), .z_out ()
    );
    hvd_cordic #(.STAGES(N), .VECTOR(1'b0)) u_rot_lb (
        .clk (clk), .en (en), .x_in (hvd_pkg::Q_ONE), .y_in ('0), .z_in (z_lb),
        .x_out (x2), .y_out (), .z_out ()
    );

    assign ya_mag = ya[63] ? (~ya + 64'd1) : ya;
    assign yb_mag = yb[63] ? (~yb + 64'd1) : yb;
    assign c1     = x1[63] ? 64'd0 : x1;
    assign c2     = x2[63] ? 64'd0 : x2;

    hvd_mul #(.SHIFT(60)) u_sq_a (
        .clk (clk), .en (en), .a (ya_mag), .b (ya_mag), .p (ya_sq)
    );
    hvd_mul #(.SHIFT(60)) u_sq_b (
        .clk (clk), .en (en), .a (yb_mag), .b (yb_mag), .p (yb_sq)
    );
    hvd_mul #(.SHIFT(60)) u_cos_prod (
        .clk (clk), .en (en), .a (c1), .b (c2), .p (c_prod)
    );

    // remove the squared cordic gain
    hvd_div #(.STAGES(N)) u_div_a (.clk (clk), .en (en), .num (ya_sq), .quo (sa));
    hvd_div #(.STAGES(N)) u_div_b (.clk (clk), .en (en), .num (yb_sq), .quo (sb));
    hvd_div #(.STAGES(N)) u_div_c (.clk (clk), .en (en), .num (c_prod), .quo (cc));

    hvd_mul #(.SHIFT(60)) u_ccsb (
        .clk (clk), .en (en), .a (cc), .b (sb), .p (ccsb)
    );

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sa_dly_reg[0] <= sa;
            for (int i = 1; i < ML; i++)
                sa_dly_reg[i] <= sa_dly_reg[i-1];
        end
    end

    assign h_sum = {1'b0, sa_dly_reg[ML-1]} + {1'b0, ccsb};

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            h_reg   <= (h_sum > {1'b0, hvd_pkg::Q_ONE}) ? hvd_pkg::Q_ONE[60:0] : h_sum[60:0];
            h2_reg  <= h_reg;
            omh_reg <= hvd_pkg::Q_ONE[60:0] - h_reg;
        end
    end

    hvd_sqrt u_sqrt_h   (.clk (clk), .en (en), .radicand (h2_reg),  .root (root_h));
    hvd_sqrt u_sqrt_omh (.clk (clk), .en (en), .radicand (omh_reg), .root (root_omh));

    // arcsine as atan2(sqrt(h), sqrt(1-h))
    hvd_cordic #(.STAGES(N), .VECTOR(1'b1)) u_vec (
        .clk (clk), .en (en), .x_in ({3'd0, root_omh}), .y_in ({3'd0, root_h}), .z_in ('0),
        .x_out (), .y_out (), .z_out (th)
    );

    assign th_pos = th[63] ? 64'd0 : th;

    hvd_mul #(.SHIFT(59)) u_scale (
        .clk (clk), .en (en), .a (th_pos), .b (hvd_pkg::TWO_R_CM), .p (q)
    );

    assign d_full = (q + 64'd1) >> 1;

    always_ff @(posedge clk)
    begin
        if (en)
            dist_reg <= (d_full > hvd_pkg::DIST_MAX) ? hvd_pkg::DIST_MAX[30:0] : d_full[30:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[LAT-2:0], pos_valid};
    end

    // output buffer
    assign push       = en & vld_reg[LAT-1];
    assign dist_valid = (cnt_reg != 2'd0);
    assign pop        = dist_valid & ~dist_stall;

    always_comb
    begin
        buf0_next = buf0_reg;
        buf1_next = buf1_reg;
        if (pop)
            buf0_next = buf1_reg;
        if (push)
        begin
            if ((cnt_reg - {1'b0, pop}) == 2'd0)
                buf0_next = dist_reg;
            else
                buf1_next = dist_reg;
        end
        cnt_next = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk)
    begin
        buf0_reg <= buf0_next;
        buf1_reg <= buf1_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= 2'd0;
        else
            cnt_reg <= cnt_next;
    end

    assign distance_cm = buf0_reg;

`ifndef SYNTHESIS
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg != 2'd3)
        else $error("output buffer count out of range");

    a_full_freezes: assert property (@(posedge clk) disable iff (!rst_n)
        pos_stall |=> $stable(vld_reg))
        else $error("pipeline moved while buffer full");

    a_pop_only: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !push) |=> (cnt_reg == $past(cnt_reg) - 2'd1))
        else $error("buffer count lost a transfer");

    a_h_capped: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[H_STG] |-> (h_reg <= hvd_pkg::Q_ONE[60:0]))
        else $error("haversine term above one");
`endif

endmodule

/* sv/hvd_mul.sv */
module hvd_mul #(
    parameter int SHIFT = 60
) (
    input  logic        clk,
    input  logic        en,
    input  logic [63:0] a,
    input  logic [63:0] b,
    output logic [63:0] p
);

    logic [63:0]  p00_reg;
    logic [63:0]  p01_reg;
    logic [63:0]  p10_reg;
    logic [63:0]  p11_reg;
    logic [63:0]  q00_reg;
    logic [63:0]  q11_reg;
    logic [64:0]  mid_reg;
    logic [63:0]  p_reg;
    logic [127:0] full_next;

    // four 32x32 partial products, then cross terms, then the full sum
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p00_reg <= a[31:0] * b[31:0];
            p01_reg <= a[31:0] * b[63:32];
            p10_reg <= a[63:32] * b[31:0];
            p11_reg <= a[63:32] * b[63:32];
            mid_reg <= {1'b0, p01_reg} + {1'b0, p10_reg};
            q00_reg <= p00_reg;
            q11_reg <= p11_reg;
            p_reg   <= full_next[SHIFT+63:SHIFT];
        end
    end

    assign full_next = {q11_reg, 64'd0} + {31'd0, mid_reg, 32'd0} + {64'd0, q00_reg};
    assign p = p_reg;

endmodule

/* sv/hvd_cordic.sv */
module hvd_cordic #(
    parameter int STAGES = hvd_pkg::CORDIC_STAGES_DEF,
    parameter bit VECTOR = 1'b0
) (
    input  logic               clk,
    input  logic               en,
    input  logic signed [63:0] x_in,
    input  logic signed [63:0] y_in,
    input  logic signed [63:0] z_in,
    output logic signed [63:0] x_out,
    output logic signed [63:0] y_out,
    output logic signed [63:0] z_out
);

    logic signed [63:0] x_reg [STAGES];
    logic signed [63:0] y_reg [STAGES];
    logic signed [63:0] z_reg [STAGES];

    for (genvar i = 0; i < STAGES; i++)
    begin : g_stage
        localparam logic signed [63:0] ANG = hvd_pkg::atan_entry(i);
        logic signed [63:0] xp;
        logic signed [63:0] yp;
        logic signed [63:0] zp;
        logic signed [63:0] x_next;
        logic signed [63:0] y_next;
        logic signed [63:0] z_next;
        logic               turn;

        if (i == 0)
        begin : g_first
            assign xp = x_in;
            assign yp = y_in;
            assign zp = z_in;
        end
        else
        begin : g_rest
            assign xp = x_reg[i-1];
            assign yp = y_reg[i-1];
            assign zp = z_reg[i-1];
        end

        // rotation steers on the residual angle, vectoring on the sign of y
        assign turn = VECTOR ? yp[63] : ~zp[63];

        always_comb
        begin
            if (turn)
            begin
                x_next = xp - (yp >>> i);
                y_next = yp + (xp >>> i);
                z_next = zp - ANG;
            end
            else
            begin
                x_next = xp + (yp >>> i);
                y_next = yp - (xp >>> i);
                z_next = zp + ANG;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                x_reg[i] <= x_next;
                y_reg[i] <= y_next;
                z_reg[i] <= z_next;
            end
        end
    end

    assign x_out = x_reg[STAGES-1];
    assign y_out = y_reg[STAGES-1];
    assign z_out = z_reg[STAGES-1];

endmodule

/* sv/hvd_div.sv */
module hvd_div #(
    parameter int STAGES = hvd_pkg::CORDIC_STAGES_DEF
) (
    input  logic        clk,
    input  logic        en,
    input  logic [63:0] num,
    output logic [63:0] quo
);

    // floor(num * 2^60 / gain^2), capped at one
    // the reciprocal estimate is exact or one low, the remainder check fixes it
    localparam logic [63:0] DEN   = hvd_pkg::gain_sq(STAGES);
    localparam logic [63:0] RECIP = hvd_pkg::recip_q124(DEN);

    logic [63:0] num_dly_reg [6];
    logic [63:0] q_dly_reg   [3];
    logic [63:0] q_est;
    logic [63:0] qd_lo;
    logic [63:0] rem;
    logic [63:0] quo_reg;

    hvd_mul #(.SHIFT(64)) u_est (
        .clk (clk), .en (en), .a (num), .b (RECIP), .p (q_est)
    );
    hvd_mul #(.SHIFT(0)) u_back (
        .clk (clk), .en (en), .a (q_est), .b (DEN), .p (qd_lo)
    );

    // remainder of num * 2^60 over the divisor, modulo 2^64
    assign rem = {num_dly_reg[5][3:0], 60'd0} - qd_lo;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            num_dly_reg[0] <= num;
            for (int i = 1; i < 6; i++)
                num_dly_reg[i] <= num_dly_reg[i-1];
            q_dly_reg[0] <= q_est;
            for (int i = 1; i < 3; i++)
                q_dly_reg[i] <= q_dly_reg[i-1];
            quo_reg <= (num_dly_reg[5] >= DEN) ? hvd_pkg::Q_ONE :
                       (rem >= DEN) ? (q_dly_reg[2] + 64'd1) : q_dly_reg[2];
        end
    end

    assign quo = quo_reg;

endmodule

/* sv/hvd_sqrt.sv */
module hvd_sqrt (
    input  logic        clk,
    input  logic        en,
    input  logic [60:0] radicand,
    output logic [60:0] root
);

    // floor(sqrt(radicand * 2^60)), one root digit per stage
    logic [62:0] rem_reg  [60];
    logic [60:0] root_reg [61];
    logic [60:0] rad_reg  [30];

    for (genvar k = 0; k <= 60; k++)
    begin : g_step
        logic [1:0]  pair;
        logic [62:0] rem_p;
        logic [60:0] root_p;
        logic [64:0] rem2;
        logic [64:0] trial;
        logic [64:0] diff;
        logic        fit;

        if (k == 0)
        begin : g_first
            assign pair   = {1'b0, radicand[60]};
            assign rem_p  = '0;
            assign root_p = '0;
        end
        else
        begin : g_rest
            assign rem_p  = rem_reg[k-1];
            assign root_p = root_reg[k-1];
            if (k <= 30)
            begin : g_bits
                assign pair = rad_reg[k-1][61-2*k -: 2];
            end
            else
            begin : g_zero
                assign pair = 2'b00;
            end
        end

        assign rem2  = {rem_p, pair};
        assign trial = {2'b00, root_p, 2'b01};
        assign diff  = rem2 - trial;
        assign fit   = (rem2 >= trial);

        always_ff @(posedge clk)
        begin
            if (en)
                root_reg[k] <= {root_p[59:0], fit};
        end

        if (k < 60)
        begin : g_rem
            always_ff @(posedge clk)
            begin
                if (en)
                    rem_reg[k] <= fit ? diff[62:0] : rem2[62:0];
            end
        end

        if (k < 30)
        begin : g_rad
            always_ff @(posedge clk)
            begin
                if (en)
                    rad_reg[k] <= (k == 0) ? radicand : rad_reg[(k == 0) ? 0 : k-1];
            end
        end
    end

    assign root = root_reg[60];

endmodule

/* test/haversine_distance_check.sv */
module haversine_distance_check (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               pos_valid,
    input  logic               pos_stall,
    input  logic signed [30:0] lat_a,
    input  logic signed [31:0] lon_a,
    input  logic signed [30:0] lat_b,
    input  logic signed [31:0] lon_b,
    input  logic               dist_valid,
    input  logic               dist_stall,
    input  logic [30:0]        distance_cm,
    output int                 errors,
    output int                 pending
);

    localparam int STAGES = (hvd_pkg::CORDIC_STAGES_DEF > hvd_pkg::MAX_STAGES) ?
                            hvd_pkg::MAX_STAGES : hvd_pkg::CORDIC_STAGES_DEF;
    localparam logic [63:0] ONE_Q60 = 64'd1 << 60;

    longint            arc_tab [STAGES];
    logic [63:0]       radian_scale;
    logic [63:0]       gain2;
    logic [30:0]       distance_q[$];

    function automatic logic [63:0] mul_floor(logic [63:0] a, logic [63:0] b, int s);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        return 64'(p >> s);
    endfunction

    function automatic logic [63:0] arctan_inv(logic [63:0] n);
        logic [63:0] p;
        logic [63:0] s;
        logic [63:0] k;
        p = (64'd1 << 62) / n;
        s = 0;
        k = 0;
        while (p != 0)
        begin
            if (k[0] == 1'b0)
                s = s + p / (2 * k + 1);
            else
                s = s - p / (2 * k + 1);
            p = p / n / n;
            k++;
        end
        return s;
    endfunction

    // quotient in q60, capped at one
    function automatic logic [63:0] frac_div(logic [63:0] num, logic [63:0] den);
        logic [127:0] q;
        if (num >= den)
            return ONE_Q60;
        q = {num, 60'd0} / {64'd0, den};
        return q[63:0];
    endfunction

    function automatic logic [63:0] root_q60(logic [63:0] h);
        logic [63:0]  r;
        logic [63:0]  t;
        logic [127:0] target;
        target = {64'd0, h} << 60;
        r = 0;
        for (int b = 60; b >= 0; b--)
        begin
            t = r | (64'd1 << b);
            if ({64'd0, t} * {64'd0, t} <= target)
                r = t;
        end
        return r;
    endfunction

    function automatic logic [63:0] magnitude(longint v);
        return (v < 0) ? 64'(-v) : 64'(v);
    endfunction

    task automatic cordic_rotate(input longint z, output longint xo, output longint yo);
        longint x;
        longint y;
        longint dx;
        longint dy;
        x = longint'(ONE_Q60);
        y = 0;
        for (int i = 0; i < STAGES; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0)
            begin
                x -= dx; y += dy; z -= arc_tab[i];
            end
            else
            begin
                x += dx; y -= dy; z += arc_tab[i];
            end
        end
        xo = x;
        yo = y;
    endtask

    function automatic longint cordic_angle(longint x, longint y);
        longint z;
        longint dx;
        longint dy;
        z = 0;
        for (int i = 0; i < STAGES; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (y >= 0)
            begin
                x += dx; y -= dy; z += arc_tab[i];
            end
            else
            begin
                x -= dx; y += dy; z -= arc_tab[i];
            end
        end
        return z;
    endfunction

    function automatic logic [63:0] sine_sq(longint y);
        logic [63:0] a;
        a = magnitude(y);
        return frac_div(mul_floor(a, a, 60), gain2);
    endfunction

    task automatic predict_distance(input logic signed [30:0] la_in,
                                    input logic signed [31:0] oa_in,
                                    input logic signed [30:0] lb_in,
                                    input logic signed [31:0] ob_in,
                                    output logic [30:0] dist_out);
        longint      la, oa, lb, ob, xa, ya, xb, yb, x1, y1, x2, y2, th;
        logic [63:0] dlat, dlon, sa, sb, c1, c2, cc, h, q, d;
        la = la_in; oa = oa_in; lb = lb_in; ob = ob_in;
        // clamp to the legal globe
        if (la > 900000000) la = 900000000;
        if (la < -900000000) la = -900000000;
        if (lb > 900000000) lb = 900000000;
        if (lb < -900000000) lb = -900000000;
        if (oa > 1800000000) oa = 1800000000;
        if (oa < -1800000000) oa = -1800000000;
        if (ob > 1800000000) ob = 1800000000;
        if (ob < -1800000000) ob = -1800000000;
        dlat = magnitude(la - lb);
        dlon = magnitude(oa - ob);
        if (dlon > 64'd1800000000)
            dlon = 64'd3600000000 - dlon;
        cordic_rotate(longint'(mul_floor(dlat, radian_scale, 13)), xa, ya);
        cordic_rotate(longint'(mul_floor(dlon, radian_scale, 13)), xb, yb);
        cordic_rotate(longint'(mul_floor(magnitude(la), radian_scale, 12)), x1, y1);
        cordic_rotate(longint'(mul_floor(magnitude(lb), radian_scale, 12)), x2, y2);
        sa = sine_sq(ya);
        sb = sine_sq(yb);
        c1 = (x1 < 0) ? 64'd0 : 64'(x1);
        c2 = (x2 < 0) ? 64'd0 : 64'(x2);
        cc = frac_div(mul_floor(c1, c2, 60), gain2);
        h = sa + mul_floor(cc, sb, 60);
        if (h > ONE_Q60)
            h = ONE_Q60;
        th = cordic_angle(longint'(root_q60(ONE_Q60 - h)), longint'(root_q60(h)));
        if (th < 0)
            th = 0;
        q = mul_floor(64'(th), 64'd1275627400, 59);
        d = (q + 1) >> 1;
        if (d > 64'h7FFF_FFFF)
            d = 64'h7FFF_FFFF;
        dist_out = d[30:0];
    endtask

    initial
    begin
        logic [127:0] num;
        logic [63:0]  v;
        num = 128'd31415926 << 72;
        radian_scale = 64'(num / 128'd18000000000000000);
        gain2 = ONE_Q60;
        for (int i = 0; i < STAGES; i++)
        begin
            gain2 = gain2 + (gain2 >> (2 * i));
            v = (i == 0) ? arctan_inv(2) + arctan_inv(3) : arctan_inv(64'd1 << i);
            arc_tab[i] = longint'((v + 2) >> 2);
        end
        errors = 0;
        pending = 0;
    end

    always @(posedge clk)
    begin
        logic [30:0] exp_dist;
        if (rst_n)
        begin
            if (pos_valid && !pos_stall)
            begin
                predict_distance(lat_a, lon_a, lat_b, lon_b, exp_dist);
                distance_q = {distance_q, exp_dist};
            end
            if (dist_valid && !dist_stall)
            begin
                if (distance_q.size() == 0)
                begin
                    $error("unexpected transfer, distance_cm actual %0d", distance_cm);
                    errors++;
                end
                else
                begin
                    exp_dist = distance_q.pop_front();
                    if (distance_cm !== exp_dist)
                    begin
                        $error("distance_cm expected %0d actual %0d", exp_dist, distance_cm);
                        errors++;
                    end
                end
            end
        end
        pending = distance_q.size();
    end

endmodule

/* test/haversine_distance_test.sv */
module haversine_distance_test;

    logic               clk;
    logic               rst_n;
    logic               pos_valid;
    logic               pos_stall;
    logic signed [30:0] lat_a;
    logic signed [31:0] lon_a;
    logic signed [30:0] lat_b;
    logic signed [31:0] lon_b;
    logic               dist_valid;
    logic               dist_stall;
    logic [30:0]        distance_cm;
    int                 errors;
    int                 pending;
    int                 idle_cycles;
    bit                 hold_now;

    haversine_distance dut (
        .clk(clk), .rst_n(rst_n),
        .pos_valid(pos_valid), .pos_stall(pos_stall),
        .lat_a(lat_a), .lon_a(lon_a), .lat_b(lat_b), .lon_b(lon_b),
        .dist_valid(dist_valid), .dist_stall(dist_stall), .distance_cm(distance_cm)
    );

    haversine_distance_check check (
        .clk(clk), .rst_n(rst_n),
        .pos_valid(pos_valid), .pos_stall(pos_stall),
        .lat_a(lat_a), .lon_a(lon_a), .lat_b(lat_b), .lon_b(lon_b),
        .dist_valid(dist_valid), .dist_stall(dist_stall), .distance_cm(distance_cm),
        .errors(errors), .pending(pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // one position pair, held until the transfer
    task automatic send_pair(input logic signed [30:0] la, input logic signed [31:0] oa,
                             input logic signed [30:0] lb, input logic signed [31:0] ob);
        pos_valid = 1'b1;
        lat_a = la; lon_a = oa; lat_b = lb; lon_b = ob;
        @(posedge clk);
        while (pos_stall)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic idle_gap(input int n);
        pos_valid = 1'b0;
        repeat (n) @(negedge clk);
    endtask

    function automatic logic signed [30:0] rand_lat();
        if ($urandom_range(0, 9) == 0)
            return 31'($urandom);
        return 31'($signed($urandom_range(0, 1800000000)) - 900000000);
    endfunction

    function automatic logic signed [31:0] rand_lon();
        if ($urandom_range(0, 9) == 0)
            return 32'($urandom);
        return 32'($urandom_range(0, 3600000000) - 32'd1800000000);
    endfunction

    // receiver: random stall pattern with stall-free stretches, and one long hold-off
    initial
    begin
        int cnt;
        dist_stall = 1'b0;
        hold_now = 1'b0;
        cnt = 0;
        forever
        begin
            @(negedge clk);
            cnt++;
            if (cnt == 200)
            begin
                hold_now = 1'b1;
                dist_stall = 1'b1;
                repeat (600) @(negedge clk);
                hold_now = 1'b0;
            end
            if ((cnt / 500) % 3 == 1)
                dist_stall = 1'b0;
            else
                dist_stall = ($urandom_range(0, 3) == 0);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (pos_valid && !pos_stall) || (dist_valid && !dist_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        @(posedge clk);
        while (idle_cycles < 5000)
            @(posedge clk);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        int burst;
        pos_valid = 1'b0;
        lat_a = '0; lon_a = '0; lat_b = '0; lon_b = '0;
        rst_n = 1'b0;
        repeat (8) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed corners
        send_pair(0, 0, 0, 0);
        send_pair(900000000, 0, -900000000, 0);
        send_pair(900000000, 1800000000, 900000000, -1800000000);
        send_pair(0, 1800000000, 0, -1800000000);
        send_pair(0, 0, 0, 1800000000);
        send_pair(0, -1800000000, 0, 0);
        send_pair(0, 1700000000, 0, -1700000000);
        send_pair(-1073741824, 32'sh8000_0000, 1073741823, 32'sh7FFF_FFFF);
        send_pair(1073741823, 32'sh7FFF_FFFF, -1073741824, 32'sh8000_0000);
        send_pair(-1, -1, 0, 0);
        send_pair(1, 1, 0, 0);
        send_pair(450000000, 900000000, -450000000, -900000000);
        send_pair(-900000000, 123456789, -900000000, -987654321);
        send_pair(515000000, -1270000, 407000000, -740000000);
        send_pair(0, 0, 0, 1);
        send_pair(899999999, 0, 900000000, 1800000000);
        send_pair(31'sh2AAA_AAAA, 32'sh5555_5555, 31'sh5555_5555, 32'shAAAA_AAAA);
        idle_gap(3);

        for (int i = 0; i < 700; )
        begin
            burst = $urandom_range(1, 30);
            for (int j = 0; j < burst; j++)
            begin
                if ($urandom_range(0, 4) == 0)
                    send_pair(rand_lat(), rand_lon(),
                              31'($urandom_range(0, 2000) - 1000),
                              32'($urandom_range(0, 2000) - 1000));
                else
                    send_pair(rand_lat(), rand_lon(), rand_lat(), rand_lon());
                i++;
            end
            if (i > 350 && i <= 350 + burst)
            begin
                // drain the whole pipeline before carrying on
                pos_valid = 1'b0;
                while (pending != 0)
                    @(negedge clk);
            end
            else if (!hold_now && $urandom_range(0, 2) != 0)
                idle_gap($urandom_range(1, 12));
        end
        pos_valid = 1'b0;

        while (pending != 0)
            @(negedge clk);
        repeat (300) @(negedge clk);
        if (errors == 0 && pending == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

/* filelist.f */
sv/hvd_pkg.sv
sv/hvd_mul.sv
sv/hvd_cordic.sv
sv/hvd_div.sv
sv/hvd_sqrt.sv
sv/haversine_distance.sv
test/haversine_distance_check.sv
test/haversine_distance_test.sv
